/* rtl/core/ttfc_pkg.sv */
// ----------------------------------------------------------------------------
// ttfc_pkg: shared types and constants of the three-tank fill controller
// Widths, register indexes, reset values and the level compare flags.
// ----------------------------------------------------------------------------
package ttfc_pkg;

    localparam int SENSOR_COUNT = 3;
    localparam int IDX_W        = 2;
    localparam int BYTE_W       = 8;
    localparam int HEIGHT_W     = 16;
    localparam int PCT_W        = 7;
    localparam int DIST_W       = 16;
    // 100 * 65535 and 127 * 65535 both fit here
    localparam int LEVEL_W      = 23;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    localparam logic [HEIGHT_W-1:0] HEIGHT_A_RST = 16'd1000;
    localparam logic [HEIGHT_W-1:0] HEIGHT_B_RST = 16'd1500;
    localparam logic [HEIGHT_W-1:0] HEIGHT_C_RST = 16'd1200;
    localparam logic [PCT_W-1:0]    LOW_PCT_RST   = 7'd25;
    localparam logic [PCT_W-1:0]    FULL_PCT_RST  = 7'd95;
    localparam logic [PCT_W-1:0]    EMPTY_PCT_RST = 7'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT_A  = 3'd0,
        CFG_HEIGHT_B  = 3'd1,
        CFG_HEIGHT_C  = 3'd2,
        CFG_LOW_PCT   = 3'd3,
        CFG_FULL_PCT  = 3'd4,
        CFG_EMPTY_PCT = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    // threshold compare results for one drum
    typedef struct packed {
        logic at_or_below_low;
        logic at_or_above_full;
        logic at_or_below_empty;
    } t_level_flags;

endpackage

/* rtl/core/ttfc_level_cmp.sv */
// ----------------------------------------------------------------------------
// ttfc_level_cmp: drum level against the three percent thresholds
// Compares 100*(height-distance) with pct*height; both sides are formed
// combinationally from the configuration and the stored distance.
// ----------------------------------------------------------------------------
module ttfc_level_cmp (
    input  logic [ttfc_pkg::HEIGHT_W-1:0]  i_height,
    input  logic [ttfc_pkg::PCT_W-1:0]     i_low_pct,
    input  logic [ttfc_pkg::PCT_W-1:0]     i_full_pct,
    input  logic [ttfc_pkg::PCT_W-1:0]     i_empty_pct,
    input  logic [ttfc_pkg::DIST_W-1:0]    i_distance,
    output ttfc_pkg::t_level_flags         o_flags
);
    import ttfc_pkg::*;

    logic [HEIGHT_W-1:0] w_den;
    logic [HEIGHT_W-1:0] w_diff;
    logic [LEVEL_W-1:0]  w_num;
    logic [LEVEL_W-1:0]  w_low_thr;
    logic [LEVEL_W-1:0]  w_full_thr;
    logic [LEVEL_W-1:0]  w_empty_thr;

    // zero height reads as level 0 over a denominator of 1
    assign w_den  = (i_height == '0) ? HEIGHT_W'(1) : i_height;
    assign w_diff = i_height - i_distance;

    always_comb begin
        if (i_height == '0 || i_distance > i_height) begin
            w_num = '0;
        end else begin
            // times 100 = 64 + 32 + 4
            w_num = LEVEL_W'({w_diff, 6'b0}) + LEVEL_W'({w_diff, 5'b0})
                  + LEVEL_W'({w_diff, 2'b0});
        end
    end

    assign w_low_thr   = {{(LEVEL_W-PCT_W){1'b0}}, i_low_pct}
                       * {{(LEVEL_W-HEIGHT_W){1'b0}}, w_den};
    assign w_full_thr  = {{(LEVEL_W-PCT_W){1'b0}}, i_full_pct}
                       * {{(LEVEL_W-HEIGHT_W){1'b0}}, w_den};
    assign w_empty_thr = {{(LEVEL_W-PCT_W){1'b0}}, i_empty_pct}
                       * {{(LEVEL_W-HEIGHT_W){1'b0}}, w_den};

    assign o_flags.at_or_below_low   = (w_num <= w_low_thr);
    assign o_flags.at_or_above_full  = (w_num >= w_full_thr);
    assign o_flags.at_or_below_empty = (w_num <= w_empty_thr);

endmodule

/* rtl/core/three_tank_fill_controller.sv */
// ----------------------------------------------------------------------------
// three_tank_fill_controller: sensor frame parser and two-drum fill control
// Parses 0xFF/high/low/sum frames per sensor and runs hysteresis fill
// control for drums A and B on each tick.
// ----------------------------------------------------------------------------
// Each input beat passes the input register, then the result register, and
// gives exactly one result beat. Throughput: one beat per cycle while m_tready
// holds; output stalls back up through the two stages.
// Reset (synchronous, active low) restores the register defaults, puts every
// parser in the start-byte wait, clears stored distances and all fill flags.
module three_tank_fill_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [ttfc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ttfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] sensor_index, [9:2] byte_value, [15:10] zero
    input  logic [ttfc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] kind
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] valve_b_to_a, [1] valve_c_to_b, [2] low_source_alarm,
    // [3] frame_good, [4] frame_bad, [20:5] frame_distance, [23:21] zero
    output logic [ttfc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import ttfc_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_SUM  = 2'd3
    } t_phase;

    // configuration
    logic [HEIGHT_W-1:0] r_height_a, r_height_b, r_height_c;
    logic [PCT_W-1:0]    r_low_pct, r_full_pct, r_empty_pct;

    // input stage
    logic                r_in_valid;
    t_kind               r_in_kind;
    logic [IDX_W-1:0]    r_in_idx;
    logic [BYTE_W-1:0]   r_in_byte;

    // per-sensor parser state
    t_phase              r_phase [SENSOR_COUNT];
    logic [BYTE_W-1:0]   r_high  [SENSOR_COUNT];
    logic [BYTE_W-1:0]   r_low   [SENSOR_COUNT];
    logic [DIST_W-1:0]   r_dist  [SENSOR_COUNT];

    logic                r_filling_a, r_filling_b, r_alarm;

    // result stage
    logic                r_out_valid;
    logic                r_out_good, r_out_bad;
    logic [DIST_W-1:0]   r_out_dist;

    logic                w_out_adv;
    logic                w_fire;
    logic                w_idx_ok;
    logic [IDX_W-1:0]    w_sel;
    logic [BYTE_W-1:0]   w_sum;
    logic [DIST_W-1:0]   w_frame_dist;
    logic                n_filling_a, n_filling_b, n_alarm;
    logic                n_good, n_bad;
    t_level_flags        w_fa, w_fb, w_fc;

    assign w_out_adv = !r_out_valid || m_tready;
    assign w_fire    = r_in_valid && w_out_adv;
    assign s_tready  = !r_in_valid || w_out_adv;

    assign w_idx_ok     = (r_in_idx < IDX_W'(SENSOR_COUNT));
    assign w_sel        = w_idx_ok ? r_in_idx : '0;
    assign w_sum        = SYNC_BYTE + r_high[w_sel] + r_low[w_sel];
    assign w_frame_dist = {r_high[w_sel], r_low[w_sel]};

    ttfc_level_cmp u_level_a (
        .i_height    (r_height_a),
        .i_low_pct   (r_low_pct),
        .i_full_pct  (r_full_pct),
        .i_empty_pct (r_empty_pct),
        .i_distance  (r_dist[0]),
        .o_flags     (w_fa)
    );

    ttfc_level_cmp u_level_b (
        .i_height    (r_height_b),
        .i_low_pct   (r_low_pct),
        .i_full_pct  (r_full_pct),
        .i_empty_pct (r_empty_pct),
        .i_distance  (r_dist[1]),
        .o_flags     (w_fb)
    );

    ttfc_level_cmp u_level_c (
        .i_height    (r_height_c),
        .i_low_pct   (r_low_pct),
        .i_full_pct  (r_full_pct),
        .i_empty_pct (r_empty_pct),
        .i_distance  (r_dist[2]),
        .o_flags     (w_fc)
    );

    // fill control for a tick
    always_comb begin
        n_filling_a = r_filling_a;
        n_filling_b = r_filling_b;
        n_alarm     = r_alarm;
        if (r_in_kind == KIND_TICK) begin
            if (!r_filling_a) begin
                n_filling_a = w_fa.at_or_below_low && !w_fb.at_or_below_empty;
            end else if (w_fa.at_or_above_full || w_fb.at_or_below_empty) begin
                n_filling_a = 1'b0;
            end
            if (n_filling_a) begin
                n_filling_b = 1'b0;
            end else if (!r_filling_b) begin
                n_filling_b = w_fb.at_or_below_low && !w_fc.at_or_below_empty;
            end else if (w_fb.at_or_above_full || w_fc.at_or_below_empty) begin
                n_filling_b = 1'b0;
            end
            n_alarm = w_fc.at_or_below_low;
        end
    end

    assign n_good = (r_in_kind == KIND_BYTE) && w_idx_ok
                 && (r_phase[w_sel] == PH_SUM) && (w_sum == r_in_byte);
    assign n_bad  = (r_in_kind == KIND_BYTE) && w_idx_ok
                 && (r_phase[w_sel] == PH_SUM) && (w_sum != r_in_byte);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height_a  <= HEIGHT_A_RST;
            r_height_b  <= HEIGHT_B_RST;
            r_height_c  <= HEIGHT_C_RST;
            r_low_pct   <= LOW_PCT_RST;
            r_full_pct  <= FULL_PCT_RST;
            r_empty_pct <= EMPTY_PCT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEIGHT_A:  r_height_a  <= i_cfg_data;
                CFG_HEIGHT_B:  r_height_b  <= i_cfg_data;
                CFG_HEIGHT_C:  r_height_c  <= i_cfg_data;
                CFG_LOW_PCT:   r_low_pct   <= i_cfg_data[PCT_W-1:0];
                CFG_FULL_PCT:  r_full_pct  <= i_cfg_data[PCT_W-1:0];
                CFG_EMPTY_PCT: r_empty_pct <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            r_in_kind <= t_kind'(s_tuser);
            r_in_idx  <= s_tdata[IDX_W-1:0];
            r_in_byte <= s_tdata[IDX_W +: BYTE_W];
        end
    end

    // parser and control state, updated as a beat moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_phase[i] <= PH_WAIT;
                r_high[i]  <= '0;
                r_low[i]   <= '0;
                r_dist[i]  <= '0;
            end
            r_filling_a <= 1'b0;
            r_filling_b <= 1'b0;
            r_alarm     <= 1'b0;
        end else if (w_fire) begin
            r_filling_a <= n_filling_a;
            r_filling_b <= n_filling_b;
            r_alarm     <= n_alarm;
            if (r_in_kind == KIND_BYTE && w_idx_ok) begin
                case (r_phase[w_sel])
                    PH_WAIT: begin
                        if (r_in_byte == SYNC_BYTE) begin
                            r_phase[w_sel] <= PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        r_high[w_sel]  <= r_in_byte;
                        r_phase[w_sel] <= PH_LOW;
                    end
                    PH_LOW: begin
                        r_low[w_sel]   <= r_in_byte;
                        r_phase[w_sel] <= PH_SUM;
                    end
                    PH_SUM: begin
                        if (w_sum == r_in_byte) begin
                            r_dist[w_sel] <= w_frame_dist;
                        end
                        r_phase[w_sel] <= PH_WAIT;
                    end
                    default: r_phase[w_sel] <= PH_WAIT;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_out_good <= n_good;
            r_out_bad  <= n_bad;
            r_out_dist <= n_good ? w_frame_dist : '0;
        end
    end

    // valve and alarm bits follow the state left by the last beat moved to the result stage
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_out_dist, r_out_bad, r_out_good,
                       r_alarm, r_filling_b, r_filling_a};

endmodule

/* verif/tb_three_tank_fill_controller.sv */
// ----------------------------------------------------------------------------
// tb_three_tank_fill_controller: self-checking bench for the fill controller
// Drives sensor bytes and control ticks, predicts each result beat with a
// cycle-free model of the frame parsers and the two-drum hysteresis control,
// and compares every result beat field by field under random back-pressure.
// ----------------------------------------------------------------------------
module tb_three_tank_fill_controller;
    import ttfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum logic [1:0] {
        WAIT_START = 2'd0,
        GOT_START  = 2'd1,
        GOT_HIGH   = 2'd2,
        GOT_LOW    = 2'd3
    } parse_phase_t;

    // same bit order as m_tdata[20:0]
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              bad;
        logic              good;
        logic              alarm;
        logic              valve_cb;
        logic              valve_ba;
    } fill_result_t;

    class fill_scoreboard;
        logic [HEIGHT_W-1:0] height [SENSOR_COUNT];
        logic [PCT_W-1:0]    low_pct, full_pct, empty_pct;
        parse_phase_t        phase [SENSOR_COUNT];
        logic [BYTE_W-1:0]   hi_byte [SENSOR_COUNT];
        logic [BYTE_W-1:0]   lo_byte [SENSOR_COUNT];
        logic [DIST_W-1:0]   stored_dist [SENSOR_COUNT];
        logic                fill_a, fill_b, alarm;
        fill_result_t        expected_q [$];
        int                  errors, beats, ticks, good_frames, bad_frames;
        int                  valve_ticks, alarm_ticks;

        function void reset_state();
            height[0] = HEIGHT_A_RST;
            height[1] = HEIGHT_B_RST;
            height[2] = HEIGHT_C_RST;
            low_pct   = LOW_PCT_RST;
            full_pct  = FULL_PCT_RST;
            empty_pct = EMPTY_PCT_RST;
            for (int s = 0; s < SENSOR_COUNT; s++) begin
                phase[s]       = WAIT_START;
                hi_byte[s]     = '0;
                lo_byte[s]     = '0;
                stored_dist[s] = '0;
            end
            fill_a = 1'b0;
            fill_b = 1'b0;
            alarm  = 1'b0;
        endfunction

        function void set_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_HEIGHT_A:  height[0] = value;
                CFG_HEIGHT_B:  height[1] = value;
                CFG_HEIGHT_C:  height[2] = value;
                CFG_LOW_PCT:   low_pct   = value[PCT_W-1:0];
                CFG_FULL_PCT:  full_pct  = value[PCT_W-1:0];
                CFG_EMPTY_PCT: empty_pct = value[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        // level in percent is num/den; zero height reads as an empty drum
        function void level_of(int s, output logic [31:0] num, output logic [31:0] den);
            if (height[s] == '0) begin
                num = 32'd0;
                den = 32'd1;
            end else begin
                num = (stored_dist[s] > height[s]) ? 32'd0 :
                      32'd100 * (32'(height[s]) - 32'(stored_dist[s]));
                den = 32'(height[s]);
            end
        endfunction

        function bit at_or_below(int s, logic [PCT_W-1:0] pct);
            logic [31:0] num, den;
            level_of(s, num, den);
            return num <= 32'(pct) * den;
        endfunction

        function bit at_or_above(int s, logic [PCT_W-1:0] pct);
            logic [31:0] num, den;
            level_of(s, num, den);
            return num >= 32'(pct) * den;
        endfunction

        function void run_control();
            if (!fill_a) begin
                if (at_or_below(0, low_pct) && !at_or_below(1, empty_pct))
                    fill_a = 1'b1;
            end else if (at_or_above(0, full_pct) || at_or_below(1, empty_pct)) begin
                fill_a = 1'b0;
            end
            if (!fill_a) begin
                if (!fill_b) begin
                    if (at_or_below(1, low_pct) && !at_or_below(2, empty_pct))
                        fill_b = 1'b1;
                end else if (at_or_above(1, full_pct) || at_or_below(2, empty_pct)) begin
                    fill_b = 1'b0;
                end
            end else begin
                fill_b = 1'b0;
            end
            alarm = at_or_below(2, low_pct);
        endfunction

        function void note_input(t_kind kind, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            fill_result_t res;
            logic [BYTE_W-1:0] sum;
            res = '0;
            beats++;
            if (kind == KIND_TICK) begin
                ticks++;
                run_control();
                if (fill_a || fill_b) valve_ticks++;
                if (alarm) alarm_ticks++;
            end else if (idx < SENSOR_COUNT) begin
                case (phase[idx])
                    WAIT_START: if (val == SYNC_BYTE) phase[idx] = GOT_START;
                    GOT_START: begin
                        hi_byte[idx] = val;
                        phase[idx]   = GOT_HIGH;
                    end
                    GOT_HIGH: begin
                        lo_byte[idx] = val;
                        phase[idx]   = GOT_LOW;
                    end
                    default: begin
                        sum = SYNC_BYTE + hi_byte[idx] + lo_byte[idx];
                        if (sum == val) begin
                            stored_dist[idx] = {hi_byte[idx], lo_byte[idx]};
                            res.good         = 1'b1;
                            res.distance     = stored_dist[idx];
                            good_frames++;
                        end else begin
                            res.bad = 1'b1;
                            bad_frames++;
                        end
                        phase[idx] = WAIT_START;
                    end
                endcase
            end
            res.valve_ba = fill_a;
            res.valve_cb = fill_b;
            res.alarm    = alarm;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            fill_result_t want, got;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat %h with nothing expected", $time, data);
                return;
            end
            want = expected_q.pop_front();
            got  = data[20:0];
            compare_field("valve_b_to_a", 16'(want.valve_ba), 16'(got.valve_ba));
            compare_field("valve_c_to_b", 16'(want.valve_cb), 16'(got.valve_cb));
            compare_field("low_source_alarm", 16'(want.alarm), 16'(got.alarm));
            compare_field("frame_good", 16'(want.good), 16'(got.good));
            compare_field("frame_bad", 16'(want.bad), 16'(got.bad));
            compare_field("frame_distance", want.distance, got.distance);
            compare_field("padding", 16'd0, 16'(data[23:21]));
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    fill_scoreboard sb;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_sent     = 0;
    int ignored_sent   = 0;
    int settings_used  = 1;
    int idle_cycles    = 0;

    three_tank_fill_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // result checked before the input is noted, so a beat can never match
    // the expectation of an item accepted at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready) sb.note_input(t_kind'(s_tuser), s_tdata[1:0], s_tdata[9:2]);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_three_tank_fill_controller: FAIL");
            $finish;
        end
    end

    task automatic send_item(input t_kind kind, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, val, idx};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        if (kind == KIND_BYTE && idx == 2'd3) ignored_sent++;
    endtask

    task automatic send_frame(input logic [IDX_W-1:0] idx, input logic [DIST_W-1:0] d,
                              input bit corrupt);
        logic [BYTE_W-1:0] sum;
        sum = SYNC_BYTE + d[15:8] + d[7:0];
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        send_item(KIND_BYTE, idx, SYNC_BYTE);
        send_item(KIND_BYTE, idx, d[15:8]);
        send_item(KIND_BYTE, idx, d[7:0]);
        send_item(KIND_BYTE, idx, sum);
    endtask

    // half the distances cluster around the threshold crossings of the current setting, the rest are random
    function automatic logic [DIST_W-1:0] pick_distance(int s);
        int h, t, d;
        h = sb.height[s];
        case ($urandom_range(5))
            0, 1, 2: begin
                case ($urandom_range(2))
                    0: t = sb.low_pct;
                    1: t = sb.full_pct;
                    default: t = sb.empty_pct;
                endcase
                d = (t > 100) ? 0 : h - (t * h) / 100;
                d = d + int'($urandom_range(2)) - 1;
            end
            3, 4: d = $urandom_range(h + 5);
            default: d = $urandom_range(65535);
        endcase
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return d[DIST_W-1:0];
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [15:0] ha, input logic [15:0] hb,
                                  input logic [15:0] hc, input logic [15:0] lo,
                                  input logic [15:0] fu, input logic [15:0] em);
        logic [15:0] vals [6];
        vals = '{ha, hb, hc, lo, fu, em};
        for (int r = 0; r < 6; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r[CFG_IDX_W-1:0];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            sb.set_cfg(t_cfg_idx'(r), vals[r]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int n);
        int start, r, idx, extra;
        start = items_sent - ignored_sent;
        while (items_sent - ignored_sent - start < n) begin
            r   = $urandom_range(99);
            idx = $urandom_range(2);
            if (r < 55) begin
                send_frame(IDX_W'(idx), pick_distance(idx), $urandom_range(9) == 0);
            end else if (r < 80) begin
                send_item(KIND_TICK, IDX_W'($urandom_range(3)),
                          BYTE_W'($urandom_range(255)));
            end else if (r < 93) begin
                send_item(KIND_BYTE, IDX_W'($urandom_range(3)),
                          $urandom_range(3) == 0 ? SYNC_BYTE : 8'($urandom_range(255)));
            end else begin
                // broken frame: start byte and one or two data bytes only
                extra = $urandom_range(1, 2);
                send_item(KIND_BYTE, IDX_W'(idx), SYNC_BYTE);
                repeat (extra) send_item(KIND_BYTE, IDX_W'(idx),
                                         BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_phase(input int mode, input int n);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
            default: begin src_idle_pct = 26; sink_stall_pct = 26; end
        endcase
        run_random(n);
        drain();
    endtask

    initial begin
        sb = new;
        sb.reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset levels, ignored bytes, good and bad frames, 0xFF as data
        send_item(KIND_TICK, 2'd0, 8'h00);
        send_item(KIND_BYTE, 2'd0, 8'h00);
        send_item(KIND_BYTE, 2'd3, SYNC_BYTE);
        send_frame(2'd0, 16'd1000, 1'b0);
        send_item(KIND_TICK, 2'd1, 8'h55);
        send_frame(2'd1, 16'd0, 1'b1);
        send_frame(2'd2, 16'hFFFF, 1'b0);
        send_item(KIND_TICK, 2'd3, SYNC_BYTE);
        send_frame(2'd1, 16'd1500, 1'b0);
        send_item(KIND_TICK, 2'd2, 8'hAA);
        send_frame(2'd0, 16'd0, 1'b0);
        send_item(KIND_TICK, 2'd0, 8'hFF);
        drain();

        run_phase(0, 190);
        write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd100, 16'd0);
        run_phase(1, 185);
        write_settings(16'd1, 16'd1, 16'd1, 16'd100, 16'd100, 16'd100);
        run_phase(2, 185);
        // zero heights and thresholds above one hundred
        write_settings(16'd0, 16'd300, 16'd0, 16'd127, 16'd101, 16'd127);
        run_phase(3, 185);
        write_settings(16'd200, 16'd50, 16'd1000, 16'd50, 16'd60, 16'd10);
        run_phase(4, 185);
        write_settings(HEIGHT_A_RST, HEIGHT_B_RST, HEIGHT_C_RST,
                       16'(LOW_PCT_RST), 16'(FULL_PCT_RST), 16'(EMPTY_PCT_RST));
        run_phase(5, 185);
        write_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                       16'($urandom_range(1, 65535)), 16'($urandom_range(0, 40)),
                       16'($urandom_range(60, 100)), 16'($urandom_range(0, 20)));
        run_phase(6, 185);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d input beats: %0d ticks, %0d good and %0d bad frames, %0d settings.",
                 sb.beats, sb.ticks, sb.good_frames, sb.bad_frames, settings_used);
        $display("A valve was open after %0d ticks; the low-source alarm after %0d.",
                 sb.valve_ticks, sb.alarm_ticks);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_three_tank_fill_controller: PASS");
        else
            $display("tb_three_tank_fill_controller: FAIL");
        $finish;
    end

endmodule
